[rtl/fcd_pkg.sv]
package fcd_pkg;

  // One sensor snapshot.
  typedef struct packed {
    logic [15:0] gap;
    logic [11:0] own_speed;
    logic [7:0]  own_decel;
    logic [11:0] closing_speed;
    logic [11:0] front_speed_before;
    logic [11:0] front_speed_now;
    logic [23:0] sample_interval;
  } fcd_in_t;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActWarn   = 2'd1,
    ActCruise = 2'd2,
    ActBrake  = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic        front_decelerating;
    logic [9:0]  critical_distance;
  } fcd_out_t;

  typedef enum logic [2:0] {
    RegBrakeBuild = 3'd0,
    RegBrakeReact = 3'd1,
    RegHumanReact = 3'd2,
    RegMinGap     = 3'd3,
    RegWarnLimit  = 3'd4
  } reg_idx_e;

  localparam int AddrW  = 5;
  localparam int DivW   = 32;
  localparam int DivLat = DivW;

  localparam logic [15:0] BrakeBuildRst = 16'd500;
  localparam logic [15:0] BrakeReactRst = 16'd200;
  localparam logic [15:0] HumanReactRst = 16'd1000;
  localparam logic [15:0] MinGapRst     = 16'd5;
  localparam logic [15:0] WarnLimitRst  = 16'd100;

  localparam logic [9:0]  DistCap    = 10'd1000;
  localparam logic [19:0] UsPerS     = 20'd1000000;
  localparam logic [9:0]  MsPerS     = 10'd1000;
  // floor(x/1000) == (x*RecipMs)>>40 for every x below 2^30.
  localparam logic [30:0] RecipMs    = 31'd1099511628;
  localparam int          RecipShift = 40;
  // floor(d/3) == (d*683)>>11 for every d up to the cap.
  localparam logic [9:0]  ThirdMul   = 10'd683;
  localparam int          ThirdShift = 11;

endpackage

[rtl/fcd_div.sv]
// Unsigned restoring divider, one quotient bit per pipeline stage.
module fcd_div (
  input  logic                     clk_i,
  input  logic [fcd_pkg::DivW-1:0] num_i,
  input  logic [fcd_pkg::DivW-1:0] den_i,
  output logic [fcd_pkg::DivW-1:0] quo_o
);

  localparam int W = fcd_pkg::DivW;

  logic [W-1:0] n_q [W];
  logic [W-1:0] r_q [W];
  logic [W-1:0] q_q [W];
  logic [W-1:0] d_q [W];

  logic [W-1:0] n_c [W];
  logic [W-1:0] r_c [W];
  logic [W-1:0] q_c [W];
  logic [W-1:0] d_c [W];
  logic [W:0]   trial [W];
  logic [W-1:0] ge;

  always_comb begin
    for (int k = 0; k < W; k++) begin
      if (k == 0) begin
        n_c[k] = num_i;
        r_c[k] = '0;
        q_c[k] = '0;
        d_c[k] = den_i;
      end else begin
        n_c[k] = n_q[k-1];
        r_c[k] = r_q[k-1];
        q_c[k] = q_q[k-1];
        d_c[k] = d_q[k-1];
      end
      trial[k] = {r_c[k], n_c[k][W-1]};
      ge[k]    = trial[k] >= {1'b0, d_c[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < W; k++) begin
      n_q[k] <= {n_c[k][W-2:0], 1'b0};
      d_q[k] <= d_c[k];
      q_q[k] <= {q_c[k][W-2:0], ge[k]};
      if (ge[k]) begin
        r_q[k] <= W'(trial[k] - {1'b0, d_c[k]});
      end else begin
        r_q[k] <= trial[k][W-1:0];
      end
    end
  end

  assign quo_o = q_q[W-1];

endmodule

[rtl/forward_collision_decision_core.sv]
// Channel     Signals                                 Transfer
// ----------  --------------------------------------  -----------------------------
// snapshot    start_i, busy_o, in_i                   edge with start_i && !busy_o
// result      done_o, result_o                        edge ending the done_o cycle
// config      psel_i, penable_i, pwrite_i, paddr_i,   edge with psel, penable,
//             pwdata_i, prdata_o, pready_o            pwrite (pready always high)
//
// One snapshot is taken every cycle; busy_o never rises.
// Each result passes through one product stage, two chained 32-stage
// bit-per-stage dividers, and three stages for the sum, the third of the
// distance and the gap compares.
// Reset clears the valid bits and loads the register defaults.
module forward_collision_decision_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  fcd_pkg::fcd_in_t            in_i,
  output logic                        done_o,
  output fcd_pkg::fcd_out_t           result_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [fcd_pkg::AddrW-1:0]   paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  localparam int W   = fcd_pkg::DivW;
  localparam int L   = fcd_pkg::DivLat;
  localparam int Lat = 2 * fcd_pkg::DivLat + 4;

  // Configuration registers.
  logic [15:0] bbt_q, brt_q, hrt_q, mg_q, wgl_q;
  logic        wr_en;
  fcd_pkg::reg_idx_e wr_idx;

  assign pready_o = 1'b1;
  assign busy_o   = 1'b0;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign wr_idx   = fcd_pkg::reg_idx_e'(paddr_i[fcd_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bbt_q <= fcd_pkg::BrakeBuildRst;
      brt_q <= fcd_pkg::BrakeReactRst;
      hrt_q <= fcd_pkg::HumanReactRst;
      mg_q  <= fcd_pkg::MinGapRst;
      wgl_q <= fcd_pkg::WarnLimitRst;
    end else if (wr_en) begin
      unique case (wr_idx)
        fcd_pkg::RegBrakeBuild: bbt_q <= pwdata_i[15:0];
        fcd_pkg::RegBrakeReact: brt_q <= pwdata_i[15:0];
        fcd_pkg::RegHumanReact: hrt_q <= pwdata_i[15:0];
        fcd_pkg::RegMinGap:     mg_q  <= pwdata_i[15:0];
        fcd_pkg::RegWarnLimit:  wgl_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      fcd_pkg::RegBrakeBuild: prdata_o = {16'b0, bbt_q};
      fcd_pkg::RegBrakeReact: prdata_o = {16'b0, brt_q};
      fcd_pkg::RegHumanReact: prdata_o = {16'b0, hrt_q};
      fcd_pkg::RegMinGap:     prdata_o = {16'b0, mg_q};
      fcd_pkg::RegWarnLimit:  prdata_o = {16'b0, wgl_q};
      default:                prdata_o = '0;
    endcase
  end

  // Stage 1: products.
  logic        p1_vld_q;
  logic [23:0] p1_vh2_q, p1_vf2_q, p1_vfcs_q;
  logic [29:0] p1_csk_q;
  logic [28:0] p1_hv_q;
  logic [26:0] p1_csb_q;
  logic [31:0] p1_dm_q;
  logic [15:0] p1_gap_q;
  logic [7:0]  p1_ah_q;
  logic [23:0] p1_int_q;
  logic        p1_vhnz_q, p1_decel_q, p1_zero_q;

  logic        in_decel;
  logic [17:0] k_sum;
  logic [16:0] hb_sum;
  logic [11:0] dv;

  assign in_decel = in_i.front_speed_now < in_i.front_speed_before;
  assign k_sum    = {2'b0, bbt_q} + {3'b0, brt_q[15:1]} + {2'b0, hrt_q};
  assign hb_sum   = {1'b0, bbt_q} + {1'b0, hrt_q};
  assign dv       = in_i.front_speed_before - in_i.front_speed_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_vh2_q   <= 24'(in_i.own_speed) * 24'(in_i.own_speed);
    p1_vf2_q   <= 24'(in_i.front_speed_now) * 24'(in_i.front_speed_now);
    p1_vfcs_q  <= 24'(in_i.front_speed_now) * 24'(in_i.closing_speed);
    p1_csk_q   <= 30'(in_i.closing_speed) * 30'(k_sum);
    p1_hv_q    <= 29'(in_i.own_speed) * 29'(hb_sum);
    p1_csb_q   <= 27'(in_i.closing_speed) * 27'(brt_q[15:1]);
    p1_dm_q    <= 32'(dv) * 32'(fcd_pkg::UsPerS);
    p1_gap_q   <= in_i.gap;
    p1_ah_q    <= in_i.own_decel;
    p1_int_q   <= in_i.sample_interval;
    p1_vhnz_q  <= in_i.own_speed != 12'd0;
    p1_decel_q <= in_decel;
    p1_zero_q  <= (in_i.own_decel == 8'd0) ||
                  (in_decel && in_i.sample_interval == 24'd0);
  end

  // The millisecond terms are divided by 1000 through a reciprocal product
  // and then travel beside the first divider bank.
  logic [29:0] m_num1;
  logic [60:0] m_prod1, m_prod2;

  assign m_num1  = p1_decel_q ? {1'b0, p1_hv_q} : p1_csk_q;
  assign m_prod1 = 61'(m_num1) * 61'(fcd_pkg::RecipMs);
  assign m_prod2 = 61'(p1_csb_q) * 61'(fcd_pkg::RecipMs);

  // First divider bank. Lane 2 gives the front deceleration, which feeds
  // the second divider in the decelerating case.
  logic [W-1:0] a_num [3];
  logic [W-1:0] a_den [3];
  logic [W-1:0] a_quo [3];

  always_comb begin
    if (p1_decel_q) begin
      a_num[0] = 32'(p1_vh2_q);
    end else begin
      a_num[0] = 32'(p1_vh2_q) - 32'(p1_vf2_q);
    end
    a_den[0] = {23'b0, p1_ah_q, 1'b0};
    a_num[1] = 32'(p1_vfcs_q);
    a_den[1] = 32'(p1_ah_q);
    a_num[2] = p1_dm_q;
    a_den[2] = 32'(p1_int_q);
  end

  for (genvar g = 0; g < 3; g++) begin : g_diva
    fcd_div u_div (
      .clk_i (clk_i),
      .num_i (a_num[g]),
      .den_i (a_den[g]),
      .quo_o (a_quo[g])
    );
  end

  typedef struct packed {
    logic [15:0] gap;
    logic        vhnz;
    logic        decel;
    logic        zero;
    logic [23:0] vf2;
    logic [20:0] q1;
    logic [20:0] q2c;
  } side_a_t;

  side_a_t        sa_q [L];
  logic [L-1:0]   va_q;
  side_a_t        sa_in;

  assign sa_in = '{gap: p1_gap_q, vhnz: p1_vhnz_q, decel: p1_decel_q,
                   zero: p1_zero_q, vf2: p1_vf2_q,
                   q1: m_prod1[fcd_pkg::RecipShift +: 21],
                   q2c: m_prod2[fcd_pkg::RecipShift +: 21]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else begin
      va_q <= {va_q[L-2:0], p1_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q[0] <= sa_in;
    for (int k = 1; k < L; k++) begin
      sa_q[k] <= sa_q[k-1];
    end
  end

  // Second divider: front speed squared over twice the front deceleration.
  logic [W-1:0] b_den, b_quo;
  side_a_t      sa_out;

  assign sa_out = sa_q[L-1];
  assign b_den  = {a_quo[2][W-2:0], 1'b0};

  fcd_div u_divb (
    .clk_i (clk_i),
    .num_i (32'(sa_out.vf2)),
    .den_i (b_den),
    .quo_o (b_quo)
  );

  typedef struct packed {
    logic [15:0]  gap;
    logic         vhnz;
    logic         decel;
    logic         zero;
    logic [W-1:0] q0;
    logic [W-1:0] q1;
    logic [W-1:0] q2;
  } side_b_t;

  side_b_t      sb_q [L];
  logic [L-1:0] vb_q;
  side_b_t      sb_in;

  assign sb_in = '{gap: sa_out.gap, vhnz: sa_out.vhnz, decel: sa_out.decel,
                   zero: sa_out.zero || (sa_out.decel && b_den == '0),
                   q0: a_quo[0], q1: 32'(sa_out.q1),
                   q2: sa_out.decel ? 32'(sa_out.q2c) : a_quo[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else begin
      vb_q <= {vb_q[L-2:0], va_q[L-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_in;
    for (int k = 1; k < L; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
  end

  // Sum and cap.
  side_b_t      sb_out;
  logic [W-1:0] d_sum;
  logic [9:0]   d_cap;

  assign sb_out = sb_q[L-1];

  always_comb begin
    if (sb_out.decel) begin
      d_sum = sb_out.q0 - b_quo + sb_out.q1 + sb_out.q2 + 32'(mg_q);
    end else begin
      d_sum = sb_out.q0 + sb_out.q1 - sb_out.q2 + 32'(mg_q);
    end
    if (sb_out.zero || d_sum > 32'(fcd_pkg::DistCap)) begin
      d_cap = fcd_pkg::DistCap;
    end else begin
      d_cap = d_sum[9:0];
    end
  end

  logic        x_vld_q, y_vld_q;
  logic [9:0]  x_d_q, y_d_q;
  logic [15:0] x_gap_q, y_gap_q;
  logic        x_vhnz_q, y_vhnz_q, x_decel_q, y_decel_q;
  logic [8:0]  y_t_q;
  logic [19:0] third_prod;

  assign third_prod = 20'(x_d_q) * 20'(fcd_pkg::ThirdMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
      y_vld_q <= 1'b0;
    end else begin
      x_vld_q <= vb_q[L-1];
      y_vld_q <= x_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_d_q     <= d_cap;
    x_gap_q   <= sb_out.gap;
    x_vhnz_q  <= sb_out.vhnz;
    x_decel_q <= sb_out.decel;
    y_d_q     <= x_d_q;
    y_gap_q   <= x_gap_q;
    y_vhnz_q  <= x_vhnz_q;
    y_decel_q <= x_decel_q;
    y_t_q     <= 9'(third_prod >> fcd_pkg::ThirdShift);
  end

  // Gap compares against thirds of the distance.
  logic [9:0]        t_ext, t_15, t_2;
  fcd_pkg::action_e  act;

  assign t_ext = {1'b0, y_t_q};
  assign t_15  = 10'((11'(t_ext) + {t_ext, 1'b0}) >> 1);
  assign t_2   = {y_t_q, 1'b0};

  always_comb begin
    priority if (!y_vhnz_q) begin
      act = fcd_pkg::ActNone;
    end else if (y_gap_q < 16'(t_ext)) begin
      act = fcd_pkg::ActBrake;
    end else if (y_gap_q <= 16'(t_15)) begin
      act = fcd_pkg::ActCruise;
    end else if (y_gap_q <= 16'(t_2) && y_gap_q < wgl_q) begin
      act = fcd_pkg::ActWarn;
    end else begin
      act = fcd_pkg::ActNone;
    end
  end

  logic              done_q;
  fcd_pkg::fcd_out_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= y_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= '{action: act, front_decelerating: y_decel_q,
                  critical_distance: y_d_q};
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Every accepted snapshot produces its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o)
    else $error("result missing after fixed latency");

  // The distance never exceeds the cap.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.critical_distance <= fcd_pkg::DistCap)
    else $error("critical distance above cap");

  // A standing vehicle never gets an action.
  a_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !y_vhnz_q |=> done_o == $past(y_vld_q) &&
      (!done_o || result_o.action == fcd_pkg::ActNone))
    else $error("action raised for standing vehicle");

endmodule
